FILE: hw/rtl/bpf_pkg.sv
// Shared constants and types of the Bezier path flattener.
package bpf_pkg;

  localparam int COORD_BITS    = 24;
  localparam int T_FRAC_BITS   = 16;
  localparam int MAX_PRECISION = 64;

  localparam int        PREC_BITS  = 7;
  localparam logic [6:0] PREC_RESET = 7'd8;

  // control points per curve step, cubic needs four
  localparam int NPTS     = 4;
  localparam int LVL_BITS = 2;

  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_QUAD  = 2'd2,
    OP_CUBIC = 2'd3
  } op_t;

endpackage

FILE: hw/rtl/bpf_cmd_if.sv
// Path command channel: valid/ready with one command per transfer.
interface bpf_cmd_if #(
  parameter int COORD_BITS = bpf_pkg::COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [COORD_BITS-1:0] ctrl_a_x;
  logic signed [COORD_BITS-1:0] ctrl_a_y;
  logic signed [COORD_BITS-1:0] ctrl_b_x;
  logic signed [COORD_BITS-1:0] ctrl_b_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, operation, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, operation, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
    output ready
  );
endinterface

FILE: hw/rtl/bpf_vtx_if.sv
// Vertex channel: valid/ready with one polygon vertex per transfer.
interface bpf_vtx_if #(
  parameter int COORD_BITS = bpf_pkg::COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         shape_start;
  logic                         last;

  modport source (
    output valid, out_x, out_y, shape_start, last,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, shape_start, last,
    output ready
  );
endinterface

FILE: hw/rtl/bpf_recip.sv
// Restoring divider: step quotient and remainder of 2^T_FRAC_BITS by precision.
module bpf_recip #(
  parameter int T_FRAC_BITS = bpf_pkg::T_FRAC_BITS,
  parameter int PW          = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PW-1:0]          divisor,
  output logic                   done,
  output logic [T_FRAC_BITS-1:0] quot,
  output logic [PW-1:0]          rem
);

  localparam int CW = $clog2(T_FRAC_BITS + 1);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [PW-1:0]          d;
  logic [PW-1:0]          r;
  logic [T_FRAC_BITS:0]   q;
  logic [PW:0]            r_sh;
  logic                   ge;
  logic [PW-1:0]          r_next;

  // dividend is a single one at bit T_FRAC_BITS
  assign r_sh   = {r, (cnt == CW'(T_FRAC_BITS))};
  assign ge     = r_sh >= {1'b0, d};
  assign r_next = ge ? PW'(r_sh - {1'b0, d}) : r_sh[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(T_FRAC_BITS);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d <= divisor;
      r <= '0;
      q <= '0;
    end else if (busy) begin
      r <= r_next;
      q <= {q[T_FRAC_BITS-1:0], ge};
    end
  end

  assign quot = q[T_FRAC_BITS-1:0];
  assign rem  = r;

endmodule

FILE: hw/rtl/bpf_lerp.sv
// Shared lerp unit: registered (b-a)*t, then a + floor(product / 2^T_FRAC_BITS).
module bpf_lerp #(
  parameter int COORD_BITS  = bpf_pkg::COORD_BITS,
  parameter int T_FRAC_BITS = bpf_pkg::T_FRAC_BITS
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [COORD_BITS-1:0] b,
  input  logic [T_FRAC_BITS-1:0]       t,
  output logic signed [COORD_BITS-1:0] res
);

  localparam int PB = COORD_BITS + T_FRAC_BITS + 2;

  logic signed [COORD_BITS:0]   diff;
  logic signed [PB-1:0]         prod;
  logic signed [COORD_BITS-1:0] a_q;

  assign diff = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};

  always_ff @(posedge clk) begin
    prod <= diff * $signed({1'b0, t});
    a_q  <= a;
  end

  // result lies between a and b, so modular add is exact
  assign res = $signed(a_q + prod[T_FRAC_BITS +: COORD_BITS]);

endmodule

FILE: hw/rtl/bezier_path_flattener_top.sv
// Bezier path flattener: path commands in, polygon vertices out.
// Move and line, and curves with precision p of one or less, give their end point
// as a single vertex. A quadratic or cubic curve with precision p above one first
// runs a restoring divider for the step increment of t, then produces each of its
// p-1 interior vertices by de Casteljau evaluation on one shared multiplier that
// serves x and y in turn, and last its end point; the vertex output can stall.
// Precision above MAX_PRECISION is treated as MAX_PRECISION. A new command is
// taken no earlier than the cycle in which the final vertex of the previous one
// leaves the output register.
module bezier_path_flattener_top #(
  parameter int COORD_BITS    = bpf_pkg::COORD_BITS,
  parameter int T_FRAC_BITS   = bpf_pkg::T_FRAC_BITS,
  parameter int MAX_PRECISION = bpf_pkg::MAX_PRECISION
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bpf_pkg::PREC_BITS-1:0] cfg_wdata,
  bpf_cmd_if.sink                      cmd,
  bpf_vtx_if.source                    vtx
);

  localparam int PW = $clog2(MAX_PRECISION + 1);
  localparam int LB = bpf_pkg::LVL_BITS;
  localparam int NP = bpf_pkg::NPTS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_STEP, ST_LERP, ST_EMIT, ST_FINAL
  } state_t;

  typedef enum logic [1:0] {
    PH_ISSUE, PH_DROP, PH_WAIT
  } phase_t;

  typedef enum logic [1:0] {
    MO_NONE, MO_LX, MO_LY, MO_DROP
  } micro_t;

  state_t state;
  phase_t phase;
  micro_t op_q;
  micro_t op_next;

  logic [bpf_pkg::PREC_BITS-1:0] precision;
  logic signed [COORD_BITS-1:0]  prev_x, prev_y;

  logic [PW-1:0]          pc;
  logic [PW-1:0]          step;
  logic [T_FRAC_BITS-1:0] t;
  logic [PW-1:0]          rem;
  logic [LB-1:0]          deg;
  logic [LB-1:0]          lvl;
  logic [LB-1:0]          idx;
  logic                   coord;

  logic signed [COORD_BITS-1:0] ctl_x [NP];
  logic signed [COORD_BITS-1:0] ctl_y [NP];
  logic signed [COORD_BITS-1:0] wx [NP];
  logic signed [COORD_BITS-1:0] wy [NP];
  logic signed [COORD_BITS-1:0] ex, ey;

  logic                         ovalid;
  logic signed [COORD_BITS-1:0] ox, oy;
  logic                         ostart, olast;

  logic                         out_free, cmd_fire, is_curve, curve_go;
  logic [PW-1:0]                p_in;
  logic                         load_out;
  logic signed [COORD_BITS-1:0] nx, ny;
  logic                         nstart, nlast;

  logic                         div_done;
  logic [T_FRAC_BITS-1:0]       q0;
  logic [PW-1:0]                r0;
  logic [PW:0]                  rsum;
  logic                         wrap;

  logic signed [COORD_BITS-1:0] la, lb_in, lres;

  assign out_free  = !ovalid || vtx.ready;
  assign cmd.ready = (state == ST_IDLE) && out_free;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign is_curve  = (cmd.operation == bpf_pkg::OP_QUAD) ||
                     (cmd.operation == bpf_pkg::OP_CUBIC);
  assign p_in      = (precision > bpf_pkg::PREC_BITS'(MAX_PRECISION)) ?
                     PW'(MAX_PRECISION) : precision[PW-1:0];
  assign curve_go  = is_curve && (p_in > PW'(1));

  assign rsum = {1'b0, rem} + {1'b0, r0};
  assign wrap = rsum >= {1'b0, pc};

  assign la    = coord ? wy[0] : wx[0];
  assign lb_in = coord ? wy[1] : wx[1];

  bpf_recip #(
    .T_FRAC_BITS (T_FRAC_BITS),
    .PW          (PW)
  ) u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd_fire && curve_go),
    .divisor (p_in),
    .done    (div_done),
    .quot    (q0),
    .rem     (r0)
  );

  bpf_lerp #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lerp (
    .clk (clk),
    .a   (la),
    .b   (lb_in),
    .t   (t),
    .res (lres)
  );

  always_comb begin
    op_next = MO_NONE;
    if (state == ST_LERP) begin
      case (phase)
        PH_ISSUE: begin
          op_next = coord ? MO_LY : MO_LX;
        end
        PH_DROP: begin
          op_next = MO_DROP;
        end
        default: begin
          op_next = MO_NONE;
        end
      endcase
    end
  end

  always_comb begin
    load_out = 1'b0;
    nx       = ex;
    ny       = ey;
    nstart   = 1'b0;
    nlast    = 1'b1;
    case (state)
      ST_IDLE: begin
        if (cmd_fire && !curve_go) begin
          load_out = 1'b1;
          nx       = cmd.end_x;
          ny       = cmd.end_y;
          nstart   = (cmd.operation == bpf_pkg::OP_MOVE);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          nx       = wx[0];
          ny       = wy[0];
          nlast    = 1'b0;
        end
      end
      ST_FINAL: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_ISSUE;
      op_q      <= MO_NONE;
      precision <= bpf_pkg::PREC_RESET;
      prev_x    <= '0;
      prev_y    <= '0;
      ovalid    <= 1'b0;
      pc        <= '0;
      step      <= '0;
      t         <= '0;
      rem       <= '0;
      deg       <= '0;
      lvl       <= '0;
      idx       <= '0;
      coord     <= 1'b0;
    end else begin
      if (cfg_we) begin
        precision <= cfg_wdata;
      end
      ovalid <= load_out || (ovalid && !vtx.ready);
      op_q   <= op_next;
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            prev_x <= cmd.end_x;
            prev_y <= cmd.end_y;
            pc     <= p_in;
            deg    <= (cmd.operation == bpf_pkg::OP_CUBIC) ? LB'(3) : LB'(2);
            if (curve_go) begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            t     <= '0;
            rem   <= '0;
            step  <= PW'(1);
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          t     <= t + q0 + T_FRAC_BITS'(wrap);
          rem   <= wrap ? PW'(rsum - {1'b0, pc}) : rsum[PW-1:0];
          lvl   <= deg;
          idx   <= '0;
          coord <= 1'b0;
          phase <= PH_ISSUE;
          state <= ST_LERP;
        end
        ST_LERP: begin
          case (phase)
            PH_ISSUE: begin
              coord <= !coord;
              if (coord) begin
                if (idx == lvl - 1'b1) begin
                  phase <= PH_DROP;
                end else begin
                  idx <= idx + 1'b1;
                end
              end
            end
            PH_DROP: begin
              phase <= PH_WAIT;
            end
            default: begin
              idx   <= '0;
              phase <= PH_ISSUE;
              if (lvl == LB'(1)) begin
                state <= ST_EMIT;
              end else begin
                lvl <= lvl - 1'b1;
              end
            end
          endcase
        end
        ST_EMIT: begin
          if (out_free) begin
            if (step == PW'(pc - 1'b1)) begin
              state <= ST_FINAL;
            end else begin
              step  <= step + 1'b1;
              state <= ST_STEP;
            end
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      ctl_x[0] <= prev_x;
      ctl_y[0] <= prev_y;
      ctl_x[1] <= cmd.ctrl_a_x;
      ctl_y[1] <= cmd.ctrl_a_y;
      ctl_x[3] <= cmd.end_x;
      ctl_y[3] <= cmd.end_y;
      if (cmd.operation == bpf_pkg::OP_CUBIC) begin
        ctl_x[2] <= cmd.ctrl_b_x;
        ctl_y[2] <= cmd.ctrl_b_y;
      end else begin
        ctl_x[2] <= cmd.end_x;
        ctl_y[2] <= cmd.end_y;
      end
      ex <= cmd.end_x;
      ey <= cmd.end_y;
    end

    // level queue: lerp of the two front entries, pop one, push result at lvl
    if (state == ST_STEP) begin
      for (int k = 0; k < NP; k++) begin
        wx[k] <= ctl_x[k];
        wy[k] <= ctl_y[k];
      end
    end else begin
      case (op_q)
        MO_LX: begin
          for (int k = 0; k < NP - 1; k++) begin
            if (k < lvl) wx[k] <= wx[k+1];
          end
          wx[lvl] <= lres;
        end
        MO_LY: begin
          for (int k = 0; k < NP - 1; k++) begin
            if (k < lvl) wy[k] <= wy[k+1];
          end
          wy[lvl] <= lres;
        end
        MO_DROP: begin
          for (int k = 0; k < NP - 1; k++) begin
            if (k < lvl) begin
              wx[k] <= wx[k+1];
              wy[k] <= wy[k+1];
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (load_out) begin
      ox     <= nx;
      oy     <= ny;
      ostart <= nstart;
      olast  <= nlast;
    end
  end

  assign vtx.valid       = ovalid;
  assign vtx.out_x       = ox;
  assign vtx.out_y       = oy;
  assign vtx.shape_start = ostart;
  assign vtx.last        = olast;

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> ovalid || state == ST_DIV)
    else $error("accepted command neither emitted nor started");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_LERP |-> lvl != '0 && lvl <= deg)
    else $error("de Casteljau level out of range");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> step != '0 && step < pc)
    else $error("curve step out of range");

  a_drop_bubble: assert property (@(posedge clk) disable iff (rst)
    op_q == MO_DROP |=> op_q == MO_NONE)
    else $error("issue right after level drop");

endmodule
